[rtl/assert_macros.svh]
// assertion macros for the rtl files, included by key_press_capture_fifo_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising edge of clk, suspended while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check prop on every rising edge of clk, also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/kpcf_pkg.sv]
// constants and helper functions for the key press capture queue
`default_nettype none

package kpcf_pkg;

    localparam int QUEUE_DEPTH  = 4;
    localparam int NUM_SWITCHES = 5;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int RAW_W        = 5;
    localparam int CODE_W       = 3;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - CODE_W - 2;

    localparam logic FUNC_POLL  = 1'b0;
    localparam logic FUNC_GET   = 1'b1;

    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [CODE_W-1:0]       code_t;
    typedef logic [NUM_SWITCHES-1:0] levels_t;

    // ring pointer step with wrap at the queue depth
    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // highest-numbered newly pressed switch gives code index + 1, none gives 0
    function automatic code_t find_press(input levels_t rising);
        code_t code;
        code = '0;
        for (int i = 0; i < NUM_SWITCHES; i++)
        begin
            if (rising[i])
            begin
                code = CODE_W'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[rtl/key_press_capture_fifo_top.sv]
// key press edge detect with a small ring queue of key codes
// each accepted input beat gives a result beat from the output register
// throughput: one beat per cycle unless the output stalls; state update and result register load in the same cycle
// the output register stalls the input only when a result waits and m_axis_tready is low
// reset (rst_n low, asynchronous) clears the switch history, both pointers and the
// output valid; queue slots are not cleared and are only read after being written
`default_nettype none

`include "assert_macros.svh"

module key_press_capture_fifo_top
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [kpcf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [4:0] raw_switches
    input  wire logic [0:0]                         s_axis_tuser,   // [0] func

    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [kpcf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata    // [2:0] key_code,
                                                                    // [3] queued, [4] dropped
);

    logic                       s_accept;
    logic                       func;
    logic [kpcf_pkg::RAW_W-1:0] raw_switches;

    kpcf_pkg::levels_t          last_levels_reg;
    kpcf_pkg::levels_t          now_levels;
    kpcf_pkg::code_t            press_code;
    kpcf_pkg::ptr_t             wr_ptr_reg;
    kpcf_pkg::ptr_t             wr_ptr_next;
    kpcf_pkg::ptr_t             rd_ptr_reg;
    kpcf_pkg::ptr_t             rd_ptr_next;
    kpcf_pkg::ptr_t             wr_ptr_adv;
    logic                       queue_empty;
    logic                       queue_full;
    logic                       do_push;
    logic                       do_pop;
    logic                       queued_next;
    logic                       dropped_next;

    kpcf_pkg::code_t            code_store [kpcf_pkg::QUEUE_DEPTH];

    logic                       out_valid_reg;
    kpcf_pkg::code_t            out_code_reg;
    logic                       out_queued_reg;
    logic                       out_dropped_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign func          = s_axis_tuser[0];
    assign raw_switches  = s_axis_tdata[kpcf_pkg::RAW_W-1:0];

    always_comb
    begin
        // invert active-low pins so 1 means pressed
        now_levels   = ~(kpcf_pkg::NUM_SWITCHES'(raw_switches));
        press_code   = kpcf_pkg::find_press(now_levels & ~last_levels_reg);
        wr_ptr_adv   = kpcf_pkg::ptr_advance(wr_ptr_reg);
        queue_empty  = (wr_ptr_reg == rd_ptr_reg);
        queue_full   = (wr_ptr_adv == rd_ptr_reg);

        do_push      = s_accept && (func == kpcf_pkg::FUNC_POLL) &&
                       (press_code != '0) && !queue_full;
        do_pop       = s_accept && (func == kpcf_pkg::FUNC_GET) && !queue_empty;
        queued_next  = do_push;
        dropped_next = (func == kpcf_pkg::FUNC_POLL) && (press_code != '0) && queue_full;

        wr_ptr_next  = do_push ? wr_ptr_adv : wr_ptr_reg;
        rd_ptr_next  = do_pop ? kpcf_pkg::ptr_advance(rd_ptr_reg) : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_levels_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_accept && (func == kpcf_pkg::FUNC_POLL))
            begin
                last_levels_reg <= now_levels;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (s_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // queue slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            code_store[wr_ptr_reg] <= press_code;
        end
    end

    // result register, pop read taken straight from the slot array
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_code_reg    <= do_pop ? code_store[rd_ptr_reg] : '0;
            out_queued_reg  <= queued_next;
            out_dropped_reg <= dropped_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{kpcf_pkg::OUT_PAD_W{1'b0}}, out_dropped_reg, out_queued_reg,
                            out_code_reg};

    `ASSERT_CLK(a_wr_ptr_range, clk, rst_n, wr_ptr_reg <= kpcf_pkg::PTR_W'(kpcf_pkg::QUEUE_DEPTH - 1), "write pointer out of range")
    `ASSERT_CLK(a_flags_exclusive, clk, rst_n, out_valid_reg |-> !(out_queued_reg && out_dropped_reg) && !((out_queued_reg || out_dropped_reg) && (out_code_reg != '0)), "result flags conflict")
    `ASSERT_CLK(a_empty_get_zero, clk, rst_n, (s_accept && (func == kpcf_pkg::FUNC_GET) && queue_empty) |=> (out_code_reg == '0) && (rd_ptr_reg == $past(rd_ptr_reg)), "get on empty queue changed state")
    `ASSERT_CLK(a_push_advances, clk, rst_n, do_push |=> (wr_ptr_reg != $past(wr_ptr_reg)) && out_queued_reg, "push did not advance write pointer")

endmodule

`default_nettype wire
